FILE: rtl/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types and constants for the positional list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

	localparam int DEPTH_DEF      = 16;
	localparam int DATA_WIDTH_DEF = 32;

	localparam logic [1:0] ACT_INSERT = 2'd0;
	localparam logic [1:0] ACT_APPEND = 2'd1;
	localparam logic [1:0] ACT_REMOVE = 2'd2;
	localparam logic [1:0] ACT_READ   = 2'd3;

	typedef struct packed {
		logic ins;
		logic rem;
	} ple_ctl_t;

endpackage

FILE: rtl/ple_cell.sv
// ----------------------------------------------------------------------------
// ple_cell
// One list slot: holds a word, shifts from its lower or upper neighbor.
// ----------------------------------------------------------------------------
module ple_cell #(
	parameter int DATA_WIDTH = ple_pkg::DATA_WIDTH_DEF,
	parameter int POS_W      = 5,
	parameter int INDEX      = 0
) (
	input  logic                  clk,
	input  ple_pkg::ple_ctl_t     ctl,
	input  logic [POS_W-1:0]      pos,
	input  logic [DATA_WIDTH-1:0] word,
	input  logic [DATA_WIDTH-1:0] lower,
	input  logic [DATA_WIDTH-1:0] upper,
	output logic [DATA_WIDTH-1:0] q,
	output logic [DATA_WIDTH-1:0] sel
);
	import ple_pkg::*;

	localparam logic [POS_W-1:0] IDX = POS_W'(INDEX);

	logic [DATA_WIDTH-1:0] entry_q;
	logic                  hit;
	logic                  above;

	assign hit   = (pos == IDX);
	assign above = (IDX > pos);

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (hit) begin
				entry_q <= word;
			end else if (above) begin
				entry_q <= lower;
			end
		end else if (ctl.rem) begin
			if (hit || above) begin
				entry_q <= upper;
			end
		end
	end

	assign q   = entry_q;
	assign sel = hit ? entry_q : '0;

endmodule

FILE: rtl/positional_list_engine_unit.sv
// ----------------------------------------------------------------------------
// positional_list_engine_unit
// Ordered list of up to DEPTH words built from a row of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries action, position, value_in.
//   Output channel (out_valid/out_ready) carries ok, value_out, count_out,
//   exactly one result transaction per input transaction, in order.
//   Actions: insert at position, append, remove at position, read.
//   Every cell shifts in parallel, so an action finishes in the accept cycle;
//   its result is registered in the output register and shows in the next cycle.
//   Throughput: one transaction per cycle while out_ready is high; the single
//   output register sets that figure.
//   When the receiver stalls the result holds and in_ready drops until the
//   held result is taken.
//   Reset clears the count and the output valid flag; the result fields and
//   stored words are not cleared, and words are only ever read after being
//   written.
// ----------------------------------------------------------------------------
module positional_list_engine_unit #(
	parameter int DEPTH      = ple_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = ple_pkg::DATA_WIDTH_DEF,
	parameter int POS_W      = $clog2(DEPTH + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            action,
	input  logic [POS_W-1:0]      position,
	input  logic [DATA_WIDTH-1:0] value_in,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  ok,
	output logic [DATA_WIDTH-1:0] value_out,
	output logic [POS_W-1:0]      count_out
);
	import ple_pkg::*;

	localparam logic [POS_W-1:0] FULL = POS_W'(DEPTH);

	logic [POS_W-1:0]      count_q;
	logic                  out_valid_q;
	logic                  ok_q;
	logic [DATA_WIDTH-1:0] value_out_q;
	logic [POS_W-1:0]      count_out_q;

	logic                  in_fire;
	logic [POS_W-1:0]      pos_eff;
	logic                  ok_c;
	logic                  word_out_c;
	logic [POS_W-1:0]      count_nxt;
	ple_ctl_t              ctl;
	logic [DATA_WIDTH-1:0] rd_word;

	logic [DATA_WIDTH-1:0] cell_q   [DEPTH];
	logic [DATA_WIDTH-1:0] cell_sel [DEPTH];

	assign in_ready = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;

	always_comb begin
		pos_eff    = position;
		ok_c       = 1'b0;
		word_out_c = 1'b0;
		count_nxt  = count_q;
		ctl        = '0;
		unique case (action)
			ACT_INSERT: begin
				ok_c = (position <= count_q) && (count_q != FULL);
				ctl.ins = ok_c;
				if (ok_c) count_nxt = count_q + 1'b1;
			end
			ACT_APPEND: begin
				pos_eff = count_q;
				ok_c = (count_q != FULL);
				ctl.ins = ok_c;
				if (ok_c) count_nxt = count_q + 1'b1;
			end
			ACT_REMOVE: begin
				ok_c = (position < count_q);
				word_out_c = ok_c;
				ctl.rem = ok_c;
				if (ok_c) count_nxt = count_q - 1'b1;
			end
			ACT_READ: begin
				ok_c = (position < count_q);
				word_out_c = ok_c;
			end
			default: ;
		endcase
		if (!in_fire) ctl = '0;
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] lower_w;
		logic [DATA_WIDTH-1:0] upper_w;
		if (i == 0) begin : g_first
			assign lower_w = value_in;
		end else begin : g_mid_lo
			assign lower_w = cell_q[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign upper_w = cell_q[i];
		end else begin : g_mid_hi
			assign upper_w = cell_q[i+1];
		end
		ple_cell #(
			.DATA_WIDTH(DATA_WIDTH),
			.POS_W     (POS_W),
			.INDEX     (i)
		) u_cell (
			.clk  (clk),
			.ctl  (ctl),
			.pos  (pos_eff),
			.word (value_in),
			.lower(lower_w),
			.upper(upper_w),
			.q    (cell_q[i]),
			.sel  (cell_sel[i])
		);
	end

	always_comb begin
		rd_word = '0;
		for (int i = 0; i < DEPTH; i++) begin
			rd_word = rd_word | cell_sel[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				count_q     <= count_nxt;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			ok_q        <= ok_c;
			value_out_q <= word_out_c ? rd_word : '0;
			count_out_q <= count_nxt;
		end
	end

	assign out_valid = out_valid_q;
	assign ok        = ok_q;
	assign value_out = value_out_q;
	assign count_out = count_out_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL)
		else $error("list count above depth");

	a_fire_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> out_valid_q)
		else $error("accepted transaction without result");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !ok_q) |-> (value_out_q == '0))
		else $error("failed transaction returned nonzero word");

	a_count_match: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (count_out_q == count_q))
		else $error("reported count differs from list count");

	a_ins_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && ctl.ins) |=> (count_q == $past(count_q) + 1'b1))
		else $error("insert did not grow the list");

endmodule

FILE: tb/positional_list_engine_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_engine_unit_tb
// Self-checking bench for the positional list engine.
// A queue of list actions feeds a clocked driver. Each accepted transaction
// runs through an in-bench list predictor. A clocked monitor compares every
// result transaction against the oldest predicted one. Both channels idle in
// random bursts, except near the end of the run.
// ----------------------------------------------------------------------------
module positional_list_engine_unit_tb;
	import ple_pkg::*;

	localparam int DEPTH  = DEPTH_DEF;
	localparam int DW     = DATA_WIDTH_DEF;
	localparam int POS_W  = $clog2(DEPTH + 1);
	localparam int RANDOM_ITEMS = 2000;
	localparam int CALM_TAIL    = 200;

	typedef struct {
		logic [1:0]       act;
		logic [POS_W-1:0] pos;
		logic [DW-1:0]    word;
	} list_item_t;

	typedef struct {
		logic             ok;
		logic [DW-1:0]    word;
		logic [POS_W-1:0] len;
	} list_result_t;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             in_valid  = 1'b0;
	logic             in_ready;
	logic [1:0]       action    = ACT_INSERT;
	logic [POS_W-1:0] position  = '0;
	logic [DW-1:0]    value_in  = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic             ok;
	logic [DW-1:0]    value_out;
	logic [POS_W-1:0] count_out;

	list_item_t   pending_items[$];
	list_result_t expected_results[$];

	logic [DW-1:0] list_words[DEPTH];
	int            list_len;
	int            gen_len;
	int            mismatch_count;
	int            in_gap;
	int            out_stall;
	logic          calm;
	list_item_t    drive_item;
	list_result_t  seen_result;

	positional_list_engine_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (action),
		.position  (position),
		.value_in  (value_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.ok        (ok),
		.value_out (value_out),
		.count_out (count_out)
	);

	always #6 clk = ~clk;

	function automatic list_result_t apply_list_action(list_item_t it);
		list_result_t r;
		int p;
		r.ok   = 1'b0;
		r.word = '0;
		p      = it.pos;
		case (it.act)
			ACT_INSERT, ACT_APPEND: begin
				if (it.act == ACT_APPEND)
					p = list_len;
				if (p <= list_len && list_len < DEPTH) begin
					for (int i = list_len; i > p; i--)
						list_words[i] = list_words[i-1];
					list_words[p] = it.word;
					list_len++;
					r.ok = 1'b1;
				end
			end
			ACT_REMOVE: begin
				if (p < list_len) begin
					r.word = list_words[p];
					for (int i = p; i + 1 < list_len; i++)
						list_words[i] = list_words[i+1];
					list_len--;
					r.ok = 1'b1;
				end
			end
			default: begin
				if (p < list_len) begin
					r.word = list_words[p];
					r.ok   = 1'b1;
				end
			end
		endcase
		r.len = list_len[POS_W-1:0];
		return r;
	endfunction

	// queue a transaction and keep the generator's view of the list length
	task automatic queue_item(logic [1:0] act, int pos, logic [DW-1:0] word);
		list_item_t it;
		it.act  = act;
		it.pos  = pos[POS_W-1:0];
		it.word = word;
		pending_items.push_back(it);
		if (act == ACT_INSERT || act == ACT_APPEND) begin
			if ((act == ACT_APPEND || pos <= gen_len) && gen_len < DEPTH)
				gen_len++;
		end else if (act == ACT_REMOVE && pos < gen_len) begin
			gen_len--;
		end
	endtask

	function automatic logic [DW-1:0] pick_word();
		int r;
		r = $urandom_range(0, 99);
		if (r < 7)
			return '0;
		if (r < 15)
			return '1;
		return $urandom;
	endfunction

	function automatic int pick_pos(logic [1:0] act);
		int r;
		r = $urandom_range(0, 99);
		if (act == ACT_APPEND || r >= 85)
			return $urandom_range(0, (1 << POS_W) - 1);
		if (act == ACT_INSERT) begin
			if (r < 10)
				return 0;
			if (r < 20)
				return gen_len;
			return $urandom_range(0, gen_len);
		end
		if (gen_len == 0)
			return $urandom_range(0, (1 << POS_W) - 1);
		if (r < 10)
			return gen_len - 1;
		return $urandom_range(0, gen_len - 1);
	endfunction

	task automatic log_mismatch(string what);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("[%0t] mismatch: %s", $realtime, what);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_gap   <= 0;
			calm     <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				drive_item.act  = action;
				drive_item.pos  = position;
				drive_item.word = value_in;
				expected_results.push_back(apply_list_action(drive_item));
			end
			calm <= (pending_items.size() < CALM_TAIL);
			if (!in_valid || in_ready) begin
				if (in_gap > 0) begin
					in_gap   <= in_gap - 1;
					in_valid <= 1'b0;
				end else if (pending_items.size() == 0) begin
					in_valid <= 1'b0;
				end else if (!calm && $urandom_range(0, 7) == 0) begin
					in_gap   <= $urandom_range(0, 5);
					in_valid <= 1'b0;
				end else begin
					drive_item = pending_items.pop_front();
					action   <= drive_item.act;
					position <= drive_item.pos;
					value_in <= drive_item.word;
					in_valid <= 1'b1;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			out_stall <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					log_mismatch($sformatf("unexpected result ok=%0b value=%h count=%0d",
						ok, value_out, count_out));
				end else begin
					seen_result = expected_results.pop_front();
					if (ok !== seen_result.ok || value_out !== seen_result.word ||
							count_out !== seen_result.len)
						log_mismatch($sformatf(
							"exp ok=%0b value=%h count=%0d, got ok=%0b value=%h count=%0d",
							seen_result.ok, seen_result.word, seen_result.len,
							ok, value_out, count_out));
				end
			end
			if (out_stall > 0) begin
				out_stall <= out_stall - 1;
				out_ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				out_stall <= $urandom_range(0, 5);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		int mode;
		int span;
		int r;
		int n;
		logic [1:0] act;
		list_len       = 0;
		gen_len        = 0;
		mismatch_count = 0;
		foreach (list_words[i])
			list_words[i] = '0;

		// empty list, out-of-range positions
		queue_item(ACT_READ,   0, '0);
		queue_item(ACT_REMOVE, 0, '0);
		queue_item(ACT_INSERT, 1, 32'h1234_5678);
		queue_item(ACT_INSERT, 0, '1);
		queue_item(ACT_INSERT, 0, '0);
		// fill to full
		while (gen_len < DEPTH)
			queue_item(ACT_APPEND, $urandom_range(0, (1 << POS_W) - 1), $urandom);
		queue_item(ACT_APPEND, 0, 32'hdead_beef);
		queue_item(ACT_INSERT, DEPTH, 32'hcafe_f00d);
		queue_item(ACT_READ,   DEPTH, '0);
		queue_item(ACT_READ,   DEPTH - 1, '0);
		queue_item(ACT_REMOVE, (1 << POS_W) - 1, '0);
		queue_item(ACT_REMOVE, DEPTH / 2, '0);

		n = 0;
		while (n < RANDOM_ITEMS) begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(10, 60);
			for (int k = 0; k < span; k++) begin
				r = $urandom_range(0, 99);
				case (mode)
					0: act = (r < 45) ? ACT_INSERT : (r < 80) ? ACT_APPEND :
						(r < 90) ? ACT_READ : ACT_REMOVE;
					1: act = (r < 50) ? ACT_REMOVE : (r < 75) ? ACT_READ :
						(r < 90) ? ACT_INSERT : ACT_APPEND;
					default: act = 2'($urandom_range(0, 3));
				endcase
				if (mode == 3)
					queue_item(act, $urandom_range(0, (1 << POS_W) - 1), $urandom);
				else
					queue_item(act, pick_pos(act), pick_word());
				n++;
			end
		end

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (pending_items.size() == 0 && !in_valid);
		wait (expected_results.size() == 0);
		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#5ms;
		$display("status: fail");
		$finish;
	end

endmodule

FILE: sim.f
rtl/ple_pkg.sv
rtl/ple_cell.sv
rtl/positional_list_engine_unit.sv
tb/positional_list_engine_unit_tb.sv
